FILE: rtl/rgb_to_terminal_color_index_macros.svh
// ----------------------------------------------------------------------------
// rgb to terminal color index: assertion macros
// shared concurrent check forms, sampled on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef RGB_TO_TERMINAL_COLOR_INDEX_MACROS_SVH
`define RGB_TO_TERMINAL_COLOR_INDEX_MACROS_SVH

// consequent holds in the same cycle
`define RTI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the next cycle
`define RTI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// shared types, constants and arithmetic helpers of the color index mapper
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int COLOR_W  = 25;
  localparam int RGB_W    = 24;
  localparam int CH_W     = 8;
  localparam int MODE_W   = 2;
  localparam int PSIZE_W  = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 5;

  localparam int PAL_ENTRIES_DEF = 16;
  localparam int PAL_LEAVES      = 16;
  localparam int PAL_MIN         = 8;
  localparam int PAL_IDX_W       = 4;
  localparam int PAL_MID         = 4;
  localparam int DIST_W          = 18;

  localparam int PIPE_LAST = 5;

  localparam int CUBE_T0    = 48;
  localparam int CUBE_T1    = 115;
  localparam int CUBE_BASE  = 35;
  localparam int CUBE_STEP  = 40;
  localparam int CUBE_FIRST = 16;
  localparam int CUBE_R_MUL = 36;
  localparam int CUBE_G_MUL = 6;
  localparam int STEP_W     = 3;
  localparam int SUM_W      = 10;
  localparam int IDX_W      = 8;

  localparam int AVG_MUL     = 683;
  localparam int AVG_SHIFT   = 11;
  localparam int AVG_PROD_W  = 20;
  localparam int TENTH_MUL   = 205;
  localparam int TENTH_SHIFT = 11;
  localparam int TENTH_PROD_W = 16;
  localparam int GRAY_OFS    = 3;
  localparam int GRAY_STEP   = 10;
  localparam int GRAY_FIRST  = 8;
  localparam int GRAY_BASE   = 232;
  localparam int GRAY_K_MAX  = 23;
  localparam int GRAY_K_W    = 5;

  localparam logic [CH_W-1:0] CUBE_LEVEL [6] = '{
    8'h00, 8'h5F, 8'h87, 8'hAF, 8'hD7, 8'hFF
  };

  localparam logic [RGB_W-1:0] PALETTE [PAL_LEAVES] = '{
    24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00, 24'h0000EE, 24'hCD00CD,
    24'h00CDCD, 24'hE5E5E5, 24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
  };

  typedef enum logic [MODE_W-1:0] {
    MODE_FEW    = 2'd0,
    MODE_PAL    = 2'd1,
    MODE_CUBE   = 2'd2,
    MODE_DIRECT = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_MODE   = 1'b0,
    CFG_PALETTE_SIZE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } chan_t;

  typedef struct packed {
    logic                 ok;
    logic [DIST_W-1:0]    d;
    logic [PAL_IDX_W-1:0] idx;
  } node_t;

  function automatic logic [2*CH_W-1:0] sq_diff(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
    logic [CH_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return (2*CH_W)'(d) * (2*CH_W)'(d);
  endfunction

  function automatic logic [DIST_W-1:0] dist3(chan_t a, chan_t b);
    return DIST_W'(sq_diff(a.r, b.r)) + DIST_W'(sq_diff(a.g, b.g)) +
           DIST_W'(sq_diff(a.b, b.b));
  endfunction

  function automatic logic [STEP_W-1:0] cube_step(logic [CH_W-1:0] v);
    logic [STEP_W-1:0] s;
    if (v < CH_W'(CUBE_T0)) s = STEP_W'(0);
    else if (v < CH_W'(CUBE_T1)) s = STEP_W'(1);
    else if (v < CH_W'(CUBE_BASE + 3 * CUBE_STEP)) s = STEP_W'(2);
    else if (v < CH_W'(CUBE_BASE + 4 * CUBE_STEP)) s = STEP_W'(3);
    else if (v < CH_W'(CUBE_BASE + 5 * CUBE_STEP)) s = STEP_W'(4);
    else s = STEP_W'(5);
    return s;
  endfunction

  // lower index wins a tie
  function automatic node_t pick(node_t a, node_t b);
    node_t res;
    if (!b.ok) res = a;
    else if (!a.ok) res = b;
    else if (b.d < a.d) res = b;
    else res = a;
    return res;
  endfunction

endpackage

FILE: rtl/rti_pal.sv
// ----------------------------------------------------------------------------
// rti_pal
// fixed palette search: lane distances, then a registered min tree
// ----------------------------------------------------------------------------
module rti_pal #(
  parameter int PALETTE_ENTRIES = rti_pkg::PAL_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          adv,
  input  rti_pkg::chan_t                rgb,
  input  logic [rti_pkg::PSIZE_W-1:0]   n,
  output logic [rti_pkg::PAL_IDX_W-1:0] pal_idx
);
  import rti_pkg::*;

  node_t                leaf_nxt [PAL_LEAVES];
  node_t                leaf_r   [PAL_LEAVES];
  node_t                mid_nxt  [PAL_MID];
  node_t                mid_r    [PAL_MID];
  node_t                best_nxt;
  logic [PAL_IDX_W-1:0] best_r;
  logic [PAL_IDX_W-1:0] hold_r;

  // stage 2: one distance per lane
  always_comb begin
    for (int i = 0; i < PAL_LEAVES; i++) begin
      leaf_nxt[i].idx = PAL_IDX_W'(i);
      if (i < PALETTE_ENTRIES) begin
        leaf_nxt[i].ok = PSIZE_W'(i) < n;
        leaf_nxt[i].d  = dist3(rgb, chan_t'(PALETTE[i]));
      end else begin
        leaf_nxt[i].ok = 1'b0;
        leaf_nxt[i].d  = '0;
      end
    end
  end

  // stage 3: sixteen to four
  always_comb begin
    node_t l1 [PAL_LEAVES/2];
    for (int i = 0; i < PAL_LEAVES/2; i++) begin
      l1[i] = pick(leaf_r[2*i], leaf_r[2*i+1]);
    end
    for (int i = 0; i < PAL_MID; i++) begin
      mid_nxt[i] = pick(l1[2*i], l1[2*i+1]);
    end
  end

  // stage 4: four to one
  always_comb begin
    best_nxt = pick(pick(mid_r[0], mid_r[1]), pick(mid_r[2], mid_r[3]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      leaf_r <= leaf_nxt;
      mid_r  <= mid_nxt;
      best_r <= best_nxt.idx;
      hold_r <= best_r;
    end
  end

  assign pal_idx = hold_r;

endmodule

FILE: rtl/rti_cube.sv
// ----------------------------------------------------------------------------
// rti_cube
// 6-step cube quantizer with gray ramp candidate, four register stages
// ----------------------------------------------------------------------------
module rti_cube (
  input  logic                       clk,
  input  logic                       adv,
  input  rti_pkg::chan_t             rgb,
  output logic                       exact,
  output logic [rti_pkg::DIST_W-1:0] cube_dist,
  output logic [rti_pkg::DIST_W-1:0] gray_dist,
  output logic [rti_pkg::IDX_W-1:0]  cube_idx,
  output logic [rti_pkg::IDX_W-1:0]  gray_idx
);
  import rti_pkg::*;

  // stage 2
  chan_t               rgb2_r;
  logic [STEP_W-1:0]   ri2_r, gi2_r, bi2_r;
  logic [SUM_W-1:0]    sum2_r;
  // stage 3
  chan_t               rgb3_r;
  logic                exact3_r;
  logic [DIST_W-1:0]   cdist3_r;
  logic [CH_W-1:0]     avg3_r;
  logic [IDX_W-1:0]    cidx3_r;
  logic                exact3_nxt;
  logic [DIST_W-1:0]   cdist3_nxt;
  logic [CH_W-1:0]     avg3_nxt;
  logic [IDX_W-1:0]    cidx3_nxt;
  // stage 4
  chan_t               rgb4_r;
  logic                exact4_r;
  logic [DIST_W-1:0]   cdist4_r;
  logic [IDX_W-1:0]    cidx4_r;
  logic [GRAY_K_W-1:0] k4_r;
  logic [CH_W-1:0]     gv4_r;
  logic [GRAY_K_W-1:0] k4_nxt;
  logic [CH_W-1:0]     gv4_nxt;
  // stage 5
  logic                exact5_r;
  logic [DIST_W-1:0]   cdist5_r;
  logic [DIST_W-1:0]   gdist5_r;
  logic [IDX_W-1:0]    cidx5_r;
  logic [IDX_W-1:0]    gidx5_r;

  always_comb begin
    chan_t                 lvl;
    logic [AVG_PROD_W-1:0] prod;
    lvl.r      = CUBE_LEVEL[ri2_r];
    lvl.g      = CUBE_LEVEL[gi2_r];
    lvl.b      = CUBE_LEVEL[bi2_r];
    exact3_nxt = (lvl == rgb2_r);
    cdist3_nxt = dist3(rgb2_r, lvl);
    prod       = AVG_PROD_W'(sum2_r) * AVG_PROD_W'(AVG_MUL);
    avg3_nxt   = prod[AVG_SHIFT +: CH_W];
    cidx3_nxt  = IDX_W'(ri2_r) * IDX_W'(CUBE_R_MUL) + IDX_W'(gi2_r) * IDX_W'(CUBE_G_MUL) +
                 IDX_W'(bi2_r) + IDX_W'(CUBE_FIRST);
  end

  always_comb begin
    logic [CH_W-1:0]         diff;
    logic [TENTH_PROD_W-1:0] prod;
    logic [GRAY_K_W-1:0]     q;
    diff = avg3_r - CH_W'(GRAY_OFS);
    prod = TENTH_PROD_W'(diff) * TENTH_PROD_W'(TENTH_MUL);
    q    = prod[TENTH_SHIFT +: GRAY_K_W];
    if (avg3_r < CH_W'(GRAY_OFS)) k4_nxt = '0;
    else if (q > GRAY_K_W'(GRAY_K_MAX)) k4_nxt = GRAY_K_W'(GRAY_K_MAX);
    else k4_nxt = q;
    gv4_nxt = CH_W'(k4_nxt) * CH_W'(GRAY_STEP) + CH_W'(GRAY_FIRST);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rgb2_r   <= rgb;
      ri2_r    <= cube_step(rgb.r);
      gi2_r    <= cube_step(rgb.g);
      bi2_r    <= cube_step(rgb.b);
      sum2_r   <= SUM_W'(rgb.r) + SUM_W'(rgb.g) + SUM_W'(rgb.b);

      rgb3_r   <= rgb2_r;
      exact3_r <= exact3_nxt;
      cdist3_r <= cdist3_nxt;
      avg3_r   <= avg3_nxt;
      cidx3_r  <= cidx3_nxt;

      rgb4_r   <= rgb3_r;
      exact4_r <= exact3_r;
      cdist4_r <= cdist3_r;
      cidx4_r  <= cidx3_r;
      k4_r     <= k4_nxt;
      gv4_r    <= gv4_nxt;

      exact5_r <= exact4_r;
      cdist5_r <= cdist4_r;
      gdist5_r <= dist3(rgb4_r, chan_t'({gv4_r, gv4_r, gv4_r}));
      cidx5_r  <= cidx4_r;
      gidx5_r  <= IDX_W'(GRAY_BASE) + IDX_W'(k4_r);
    end
  end

  assign exact     = exact5_r;
  assign cube_dist = cdist5_r;
  assign gray_dist = gdist5_r;
  assign cube_idx  = cidx5_r;
  assign gray_idx  = gidx5_r;

endmodule

FILE: rtl/rgb_to_terminal_color_index.sv
// ----------------------------------------------------------------------------
// rgb_to_terminal_color_index
// maps a packed rgb color to a terminal color index, one beat per cycle
// ----------------------------------------------------------------------------
// usage:
//   in_valid/in_stall/in_rgb_color carry one color per beat; a negative
//   color asks for the terminal default (-1).
//   out_valid/out_stall/out_color_index return one index per input beat,
//   in order.
//   cfg_wr_en/cfg_index/cfg_wdata write color_mode (index 0) and
//   palette_size (index 1); write only while the pipeline is empty.
// stages: a result passes the input register, four compute stages and the
//   output register, in that order.
// throughput: one beat per cycle unless stalled; the palette min tree
//   and the cube/gray path are split over the same register stages.
// reset: all valid bits clear, color_mode = 2 (cube), palette_size = 16.
// stall: while the output holds a beat and out_stall is high, every stage
//   freezes and in_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module rgb_to_terminal_color_index #(
  parameter int PALETTE_ENTRIES = rti_pkg::PAL_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [rti_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rti_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [rti_pkg::COLOR_W-1:0] in_rgb_color,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rti_pkg::COLOR_W-1:0] out_color_index
);
  import rti_pkg::*;

  mode_t                 color_mode_r;
  logic [PSIZE_W-1:0]    palette_size_r;

  logic                  adv;
  logic                  v_r      [1:PIPE_LAST];
  logic                  kill_r   [1:PIPE_LAST];
  mode_t                 mode_r   [1:PIPE_LAST];
  logic [RGB_W-1:0]      direct_r [1:PIPE_LAST];
  chan_t                 rgb1_r;
  logic [PSIZE_W-1:0]    n1_r;

  logic                  kill_nxt;
  logic [RGB_W-1:0]      direct_nxt;
  logic [PSIZE_W-1:0]    n_nxt;

  logic                  exact;
  logic [DIST_W-1:0]     cube_dist;
  logic [DIST_W-1:0]     gray_dist;
  logic [IDX_W-1:0]      cube_idx;
  logic [IDX_W-1:0]      gray_idx;
  logic [PAL_IDX_W-1:0]  pal_idx;

  logic                  out_valid_r;
  logic [COLOR_W-1:0]    out_color_r;
  logic [COLOR_W-1:0]    out_color_nxt;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r   <= MODE_CUBE;
      palette_size_r <= PSIZE_W'(PAL_ENTRIES_DEF);
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_COLOR_MODE:   color_mode_r   <= mode_t'(cfg_wdata[MODE_W-1:0]);
        CFG_PALETTE_SIZE: palette_size_r <= cfg_wdata[PSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // stage 1 decode
  always_comb begin
    logic [RGB_W-1:0] c;
    c        = in_rgb_color[RGB_W-1:0];
    kill_nxt = in_rgb_color[COLOR_W-1] || (color_mode_r == MODE_FEW);
    if (c <= RGB_W'(3)) direct_nxt = '0;
    else if (c <= RGB_W'(7)) direct_nxt = RGB_W'(8);
    else direct_nxt = c;
    if (palette_size_r < PSIZE_W'(PAL_MIN)) n_nxt = PSIZE_W'(PAL_MIN);
    else if (palette_size_r > PSIZE_W'(PALETTE_ENTRIES)) n_nxt = PSIZE_W'(PALETTE_ENTRIES);
    else n_nxt = palette_size_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 1; s <= PIPE_LAST; s++) v_r[s] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v_r[1] <= in_valid;
      for (int s = 2; s <= PIPE_LAST; s++) v_r[s] <= v_r[s-1];
      out_valid_r <= v_r[PIPE_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rgb1_r      <= chan_t'(in_rgb_color[RGB_W-1:0]);
      n1_r        <= n_nxt;
      kill_r[1]   <= kill_nxt;
      mode_r[1]   <= color_mode_r;
      direct_r[1] <= direct_nxt;
      for (int s = 2; s <= PIPE_LAST; s++) begin
        kill_r[s]   <= kill_r[s-1];
        mode_r[s]   <= mode_r[s-1];
        direct_r[s] <= direct_r[s-1];
      end
      out_color_r <= out_color_nxt;
    end
  end

  rti_pal #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_pal (
    .clk     (clk),
    .adv     (adv),
    .rgb     (rgb1_r),
    .n       (n1_r),
    .pal_idx (pal_idx)
  );

  rti_cube u_cube (
    .clk       (clk),
    .adv       (adv),
    .rgb       (rgb1_r),
    .exact     (exact),
    .cube_dist (cube_dist),
    .gray_dist (gray_dist),
    .cube_idx  (cube_idx),
    .gray_idx  (gray_idx)
  );

  // final select into the output register
  always_comb begin
    if (kill_r[PIPE_LAST]) begin
      out_color_nxt = '1;
    end else begin
      case (mode_r[PIPE_LAST])
        MODE_DIRECT: out_color_nxt = COLOR_W'(direct_r[PIPE_LAST]);
        MODE_CUBE: begin
          if (!exact && (gray_dist <= cube_dist)) out_color_nxt = COLOR_W'(gray_idx);
          else out_color_nxt = COLOR_W'(cube_idx);
        end
        MODE_PAL:    out_color_nxt = COLOR_W'(pal_idx);
        default:     out_color_nxt = '1;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_color_index = out_color_r;

  `include "rgb_to_terminal_color_index_macros.svh"

  `RTI_ASSERT_NOW(a_stall_back, out_valid_r && out_stall, in_stall,
    "held output must stall input")
  `RTI_ASSERT_NEXT(a_kill_default, v_r[PIPE_LAST] && kill_r[PIPE_LAST] && adv,
    out_color_r == '1, "killed beat must give default")
  `RTI_ASSERT_NEXT(a_pal_range,
    v_r[PIPE_LAST] && !kill_r[PIPE_LAST] && mode_r[PIPE_LAST] == MODE_PAL && adv,
    out_color_r < COLOR_W'(PALETTE_ENTRIES), "palette index out of range")
  `RTI_ASSERT_NEXT(a_cube_range,
    v_r[PIPE_LAST] && !kill_r[PIPE_LAST] && mode_r[PIPE_LAST] == MODE_CUBE && adv,
    out_color_r >= COLOR_W'(CUBE_FIRST) && out_color_r <= COLOR_W'(255),
    "cube index out of range")

endmodule
